// ===== rtl/core/aes_ten_round_pseudo_encrypt_assert.svh =====
// assertion macros for the pseudo-encrypt block
`ifndef AES_TEN_ROUND_PSEUDO_ENCRYPT_ASSERT_SVH
`define AES_TEN_ROUND_PSEUDO_ENCRYPT_ASSERT_SVH
`ifndef SYNTHESIS
`define ATR_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ATR_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ATR_ASSERT_IMP(label, clk, rst, ante, cons)
`define ATR_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/core/atr_pkg.sv =====
// shared types, tables and round functions
`timescale 1ns / 1ps
package atr_pkg;
  localparam int KeyCount = 4;
  localparam logic [1:0] KEY_WORD_0 = 2'd0;
  localparam logic [1:0] KEY_WORD_1 = 2'd1;
  localparam logic [1:0] KEY_WORD_2 = 2'd2;
  localparam logic [1:0] KEY_WORD_3 = 2'd3;

  typedef struct packed {
    logic [63:0] hi;
    logic [63:0] lo;
  } block_t;

  typedef struct packed {
    logic        valid;
    logic        last;
    block_t      state;
  } slot_t;

  typedef logic [7:0] sbox_tab_t [256];
  localparam sbox_tab_t SBOX = '{
    8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
    8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
    8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
    8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
    8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
    8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
    8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
    8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
    8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
    8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
    8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
    8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
    8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
    8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
    8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
    8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16
  };

  function automatic logic [7:0] gf_double(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    logic [31:0] r;
    for (int i = 0; i < 4; i++) r[8*i +: 8] = SBOX[w[8*i +: 8]];
    return r;
  endfunction

  // shift rows, sub bytes, mix columns and key add
  function automatic block_t aes_round(input block_t s, input block_t k);
    logic [127:0] sv;
    logic [127:0] nv;
    logic [7:0]   a [4];
    logic [7:0]   all;
    sv = s;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) a[r] = SBOX[sv[32*((c + r) % 4) + 8*r +: 8]];
      all = a[0] ^ a[1] ^ a[2] ^ a[3];
      for (int r = 0; r < 4; r++)
        nv[32*c + 8*r +: 8] = a[r] ^ all ^ gf_double(a[r] ^ a[(r + 1) % 4]);
    end
    return block_t'(nv ^ 128'(k));
  endfunction
endpackage

// ===== rtl/core/atr_key_cell.sv =====
// one step of the aes-256 key schedule: two new round keys from the previous pair
`timescale 1ns / 1ps
module atr_key_cell (
  input  logic            clk,
  input  logic            load,
  input  logic [7:0]      rcon,
  input  atr_pkg::block_t prev_a,
  input  atr_pkg::block_t prev_b,
  output atr_pkg::block_t key_a,
  output atr_pkg::block_t key_b
);
  import atr_pkg::*;
  logic [31:0] w [8];
  logic [31:0] t0;
  logic [31:0] t4;
  logic [255:0] pv;
  logic [255:0] nv;

  always_comb begin
    pv = {prev_b, prev_a};
    t0 = sub_word({pv[231:224], pv[255:232]}) ^ {24'd0, rcon};
    w[0] = pv[31:0] ^ t0;
    for (int i = 1; i < 4; i++) w[i] = pv[32*i +: 32] ^ w[i-1];
    t4 = sub_word(w[3]);
    w[4] = pv[159:128] ^ t4;
    for (int i = 5; i < 8; i++) w[i] = pv[32*i +: 32] ^ w[i-1];
    for (int i = 0; i < 8; i++) nv[32*i +: 32] = w[i];
  end

  always_ff @(posedge clk) begin
    if (load) begin
      key_a <= block_t'(nv[127:0]);
      key_b <= block_t'(nv[255:128]);
    end
  end
endmodule

// ===== rtl/core/atr_round_cell.sv =====
// one pipelined aes round cell of the chain
`timescale 1ns / 1ps
module atr_round_cell (
  input  logic            clk,
  input  logic            rst,
  input  logic            advance,
  input  atr_pkg::slot_t  slot_in,
  input  atr_pkg::block_t round_key,
  output atr_pkg::slot_t  slot_out
);
  import atr_pkg::*;
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_out.valid <= 1'b0;
    end else if (advance) begin
      slot_out.valid <= slot_in.valid;
    end
    if (advance) begin
      slot_out.last  <= slot_in.last;
      slot_out.state <= aes_round(slot_in.state, round_key);
    end
  end
endmodule

// ===== rtl/core/aes_ten_round_pseudo_encrypt.sv =====
// top level: whitening, chain of round cells, key schedule and output skid
//
// usage:
// - input stream (s_axis_*) carries one 128-bit block, a whitening value and a
//   last flag per transaction; output stream (m_axis_*) carries the block after
//   ROUND_COUNT aes rounds with the last flag copied through
// - each round is one cell of a register chain; the block passes through the
//   ROUND_COUNT round cells and then the output register
// - throughput is one block per cycle while the skid register is empty; the chain
//   advances while the skid or output register is empty, and ready stays registered
// - config writes (cfg_*) load one 64-bit key word; the round keys are rebuilt
//   by a chain of key cells, one pair of round keys per cycle; the user keeps
//   the block idle while they rebuild, which the block itself does not enforce
// - reset (rst, synchronous) empties the pipeline, clears the key and
//   rebuilds the schedule of the all-zero key
// - when the receiver stalls, the skid register fills, then the chain holds
//   and ready drops
`timescale 1ns / 1ps
`include "aes_ten_round_pseudo_encrypt_assert.svh"
module aes_ten_round_pseudo_encrypt #(
  parameter int ROUND_COUNT = 10
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [255:0] s_axis_tdata,  // data_lo, data_hi, whiten_lo, whiten_hi
  input  logic         s_axis_tlast,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [127:0] m_axis_tdata,  // result_lo, result_hi
  output logic         m_axis_tlast,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [63:0]  cfg_data
);
  import atr_pkg::*;
  localparam int PairCount = (ROUND_COUNT + 1) / 2;

  logic [63:0] key_word [KeyCount];
  logic        key_load;
  block_t      key_a [PairCount + 1];
  block_t      key_b [PairCount + 1];
  logic [7:0]  rcon  [PairCount];
  slot_t       chain [ROUND_COUNT + 1];
  logic        advance;
  slot_t       skid;
  slot_t       out_reg;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < KeyCount; i++) key_word[i] <= '0;
      key_load <= 1'b1;
    end else begin
      key_load <= 1'b1;
      if (cfg_valid) begin
        case (cfg_index)
          KEY_WORD_0: key_word[0] <= cfg_data;
          KEY_WORD_1: key_word[1] <= cfg_data;
          KEY_WORD_2: key_word[2] <= cfg_data;
          KEY_WORD_3: key_word[3] <= cfg_data;
          default: key_word[0] <= key_word[0];
        endcase
      end
    end
  end

  assign key_a[0] = block_t'({key_word[1], key_word[0]});
  assign key_b[0] = block_t'({key_word[3], key_word[2]});

  always_comb begin
    rcon[0] = 8'h01;
    for (int i = 1; i < PairCount; i++) rcon[i] = gf_double(rcon[i-1]);
  end

  for (genvar g = 0; g < PairCount; g++) begin : g_key
    atr_key_cell u_key (
      .clk    (clk),
      .load   (key_load),
      .rcon   (rcon[g]),
      .prev_a (key_a[g]),
      .prev_b (key_b[g]),
      .key_a  (key_a[g+1]),
      .key_b  (key_b[g+1])
    );
  end

  assign advance = !out_reg.valid || !skid.valid;
  assign s_axis_tready = !skid.valid;

  assign chain[0].valid = s_axis_tvalid && s_axis_tready;
  assign chain[0].last  = s_axis_tlast;
  assign chain[0].state = block_t'(s_axis_tdata[127:0] ^ s_axis_tdata[255:128]);

  for (genvar r = 0; r < ROUND_COUNT; r++) begin : g_round
    atr_round_cell u_round (
      .clk       (clk),
      .rst       (rst),
      .advance   (advance),
      .slot_in   (chain[r]),
      .round_key ((r < 2) ? ((r % 2 == 0) ? key_a[0] : key_b[0])
                          : ((r % 2 == 0) ? key_a[r/2] : key_b[r/2])),
      .slot_out  (chain[r+1])
    );
  end

  // tail buffering: out_reg presents, skid catches while stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      out_reg.valid <= 1'b0;
      skid.valid    <= 1'b0;
    end else begin
      if (!out_reg.valid || m_axis_tready) begin
        if (skid.valid) begin
          out_reg    <= skid;
          skid.valid <= 1'b0;
        end else if (chain[ROUND_COUNT].valid) begin
          out_reg <= chain[ROUND_COUNT];
        end else begin
          out_reg.valid <= 1'b0;
        end
      end else if (chain[ROUND_COUNT].valid && !skid.valid) begin
        skid <= chain[ROUND_COUNT];
      end
    end
  end

  assign m_axis_tvalid = out_reg.valid;
  assign m_axis_tdata  = out_reg.state;
  assign m_axis_tlast  = out_reg.last;

  `ATR_ASSERT_NEXT(a_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
  `ATR_ASSERT_IMP(a_skid_full, clk, rst, skid.valid, out_reg.valid)
  `ATR_ASSERT_NEXT(a_skid_ready, clk, rst, !skid.valid && !chain[ROUND_COUNT].valid, s_axis_tready)
endmodule
